// ----- design/lphm_pkg.sv -----
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types, codes and sizes for the linear-probe hash map: the request and
// response payloads, the command and status bundles between controller and
// datapath, and the hash constants.
// ----------------------------------------------------------------------------
package lphm_pkg;

	// Table geometry. The slot count is a power of two, so the home slot is the
	// low bits of the mixed hash.
	localparam int SLOT_COUNT = 2048;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	// Multiplier of the xor-shift hash.
	localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// Response status codes.
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_RESERVED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_ABSENT   = 2'd3;

	// Slot key codes with special meaning.
	localparam logic [31:0] KEY_EMPTY = 32'd0;
	localparam logic [31:0] KEY_TOMB  = 32'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] found_value;
		logic [1:0]  status;
	} rsp_t;

	// Source of the word written into the key store.
	typedef enum logic [1:0] {
		WK_KEY   = 2'b01,
		WK_TOMB  = 2'b10,
		WK_EMPTY = 2'b11
	} wkey_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       load;        // capture the request
		logic       sweep_init;  // point the slot pointer at slot 0 for a clear
		logic       probe_init;  // read the home slot and restart the probe
		logic       adv;         // move to the next slot
		logic       note_free;   // remember the current slot as insert target
		logic       key_we;
		wkey_t      key_src;
		logic       val_we;
		logic       fin;         // register the response
		logic       hit;
		logic [1:0] status;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [1:0] kind;
		logic       reserved;
		logic       match;
		logic       empty;
		logic       tomb;
		logic       last;       // this is the final slot of a full circuit
		logic       free_seen;  // a tombstone was passed earlier in the chain
		logic       sweep_end;  // the slot pointer is at the last slot
	} stat_t;

endpackage

// ----- design/lphm_dp.sv -----
// ----------------------------------------------------------------------------
// lphm_dp
// Datapath of the hash map: request registers, the two-step hash, the slot
// pointer and probe counter, the key and value stores with registered reads,
// and the response register.
// ----------------------------------------------------------------------------
module lphm_dp
	import lphm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  request,
	input  cmd_t  cmd,
	output stat_t st,
	output logic  done,
	output rsp_t  response
);

	logic [1:0]        kind_q;
	logic [31:0]       key_q;
	logic [63:0]       value_q;
	logic [31:0]       mix;
	logic [31:0]       prod_q;
	logic [31:0]       fold;
	logic [SLOT_W-1:0] home;
	logic [SLOT_W-1:0] probe_q;
	logic [SLOT_W-1:0] probe_next;
	logic [SLOT_W-1:0] count_q;
	logic [SLOT_W-1:0] target_q;
	logic              tv_q;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;
	logic [31:0]       wr_key;
	logic [31:0]       key_mem [SLOT_COUNT];
	logic [63:0]       val_mem [SLOT_COUNT];
	logic [31:0]       rkey_q;
	logic [63:0]       rval_q;
	logic              done_q;
	rsp_t              rsp_q;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= request.kind;
			key_q   <= request.key;
			value_q <= request.value;
		end
	end

	// Hash, first step: fold the high half down and multiply.
	assign mix = key_q ^ (key_q >> 16);

	always_ff @(posedge clk) begin
		prod_q <= 32'(mix * HASH_MUL);
	end

	// Hash, second step: fold again and keep the slot bits.
	assign fold = prod_q ^ (prod_q >> 13);
	assign home = fold[SLOT_W-1:0];

	// Next slot with wraparound.
	assign probe_next = (probe_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : probe_q + 1'b1;

	// Slot pointer, probe counter and first free slot of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q  <= '0;
			count_q  <= '0;
			target_q <= '0;
			tv_q     <= 1'b0;
		end else begin
			if (cmd.sweep_init) begin
				probe_q <= '0;
				tv_q    <= 1'b0;
			end else if (cmd.probe_init) begin
				probe_q <= home;
				count_q <= '0;
				tv_q    <= 1'b0;
			end else if (cmd.adv) begin
				probe_q <= probe_next;
				count_q <= count_q + 1'b1;
			end
			if (cmd.note_free) begin
				target_q <= probe_q;
				tv_q     <= 1'b1;
			end
		end
	end

	// Read the home slot at the start of a probe, else the slot after this one.
	assign rd_addr = cmd.probe_init ? home : probe_next;

	// A match or a chain without an earlier tombstone writes the current slot.
	assign wr_addr = (st.match || !tv_q) ? probe_q : target_q;

	always_comb begin
		unique case (cmd.key_src)
			WK_KEY:  wr_key = key_q;
			WK_TOMB: wr_key = KEY_TOMB;
			default: wr_key = KEY_EMPTY;
		endcase
	end

	// Key store.
	always_ff @(posedge clk) begin
		if (cmd.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		rkey_q <= key_mem[rd_addr];
	end

	// Value store, read alongside the key store.
	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			val_mem[wr_addr] <= value_q;
		end
		rval_q <= val_mem[rd_addr];
	end

	// Status toward the controller.
	assign st.kind      = kind_q;
	assign st.reserved  = (key_q == KEY_EMPTY) || (key_q == KEY_TOMB);
	assign st.match     = (rkey_q == key_q);
	assign st.empty     = (rkey_q == KEY_EMPTY);
	assign st.tomb      = (rkey_q == KEY_TOMB);
	assign st.last      = (count_q == SLOT_W'(SLOT_COUNT - 1));
	assign st.free_seen = tv_q;
	assign st.sweep_end = (probe_q == SLOT_W'(SLOT_COUNT - 1));

	// Response register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.hit         <= cmd.hit;
			rsp_q.found_value <= cmd.hit ? rval_q : 64'd0;
			rsp_q.status      <= cmd.status;
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

// ----- design/lphm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphm_ctrl
// Controller of the hash map: takes a transaction, sequences hashing, the
// probe walk and the clearing sweep, and decides each store write and the
// response.
// ----------------------------------------------------------------------------
module lphm_ctrl
	import lphm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output logic  busy,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_HASH  = 5'b00010,
		S_HOME  = 5'b00100,
		S_CMP   = 5'b01000,
		S_SWEEP = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   init_q;
	logic   init_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		init_d  = init_q;
		cmd     = '0;
		cmd.key_src = WK_KEY;
		cmd.status  = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (st.kind == KIND_CLEAR) begin
					cmd.sweep_init = 1'b1;
					state_d        = S_SWEEP;
				end else if (st.reserved) begin
					cmd.fin    = 1'b1;
					cmd.status = ST_RESERVED;
					state_d    = S_IDLE;
				end else begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.probe_init = 1'b1;
				state_d        = S_CMP;
			end
			S_CMP: begin
				case (st.kind)
					KIND_INSERT: begin
						if (st.match || st.empty) begin
							cmd.key_we = 1'b1;
							cmd.val_we = 1'b1;
							cmd.fin    = 1'b1;
							state_d    = S_IDLE;
						end else begin
							cmd.note_free = st.tomb && !st.free_seen;
							if (st.last) begin
								cmd.fin = 1'b1;
								state_d = S_IDLE;
								if (st.tomb || st.free_seen) begin
									cmd.key_we = 1'b1;
									cmd.val_we = 1'b1;
								end else begin
									cmd.status = ST_FULL;
								end
							end else begin
								cmd.adv = 1'b1;
							end
						end
					end
					KIND_LOOKUP: begin
						if (st.match) begin
							cmd.fin = 1'b1;
							cmd.hit = 1'b1;
							state_d = S_IDLE;
						end else if (st.empty || st.last) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_ABSENT;
							state_d    = S_IDLE;
						end else begin
							cmd.adv = 1'b1;
						end
					end
					KIND_DELETE: begin
						if (st.match) begin
							cmd.key_we  = 1'b1;
							cmd.key_src = WK_TOMB;
							cmd.fin     = 1'b1;
							state_d     = S_IDLE;
						end else if (st.empty || st.last) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_ABSENT;
							state_d    = S_IDLE;
						end else begin
							cmd.adv = 1'b1;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SWEEP: begin
				cmd.key_we  = 1'b1;
				cmd.key_src = WK_EMPTY;
				cmd.adv     = 1'b1;
				if (st.sweep_end) begin
					cmd.fin = !init_q;
					init_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts with a sweep that empties the key store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
		end
	end

	// A transaction is only taken while idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE))
		else $error("transaction taken while busy");

	// Every response returns the controller to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (state_q == S_IDLE))
		else $error("response without return to idle");

	// A value is only written together with its key.
	a_val_key: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.val_we |-> (cmd.key_we && cmd.key_src == WK_KEY))
		else $error("value written without key");

	// The reset sweep never produces a response.
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !cmd.fin)
		else $error("response during reset sweep");

endmodule

// ----- design/linear_probe_hash_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Key-to-value map over 2048 slots with open addressing and linear probing.
// Supports insert, lookup, delete and clear of the whole table.
// ----------------------------------------------------------------------------
// Sequence: a reserved key is answered without a probe; other inserts, lookups
//   and deletes hash the key, read the home slot and then walk the chain.
// Throughput: one transaction at a time; start is taken again in the cycle
//   done is high. The probe walk reads one slot of the key store per cycle.
// Clear sweeps the key store one slot a cycle, then raises done.
// After reset the same sweep runs with busy high and no done.
// Done is high for one cycle as the registered response appears; it cannot be stalled.
module linear_probe_hash_map
	import lphm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output rsp_t response
);

	cmd_t  cmd;
	stat_t st;

	// Sequencing.
	lphm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Hash, stores and response.
	lphm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.st       (st),
		.done     (done),
		.response (response)
	);

endmodule
